[src/ala_pkg.sv]
// ---------------------------------------------------------------------------
// ala_pkg: shared constants for the ASCII line assembler
// Line store geometry, field widths, register map, result kinds, drop reason
// codes, character codes and shared types.
`default_nettype none

package ala_pkg;

  // Line store depth and derived widths
  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);

  // Payload and register widths
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int OUT_SIZE_W = 7;
  localparam int REASON_W   = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register map (byte addresses, decoded on bit 2)
  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_OUT_SIZE = 1'b1;

  localparam logic [OUT_SIZE_W-1:0] OUT_SIZE_RESET = 7'd65;
  localparam logic [OUT_SIZE_W-1:0] OUT_SIZE_MIN   = 7'd2;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  // Drop reasons
  localparam logic [REASON_W-1:0] DROP_NONE     = 2'd0;
  localparam logic [REASON_W-1:0] DROP_OVERFLOW = 2'd1;
  localparam logic [REASON_W-1:0] DROP_TOO_LONG = 2'd2;
  localparam logic [REASON_W-1:0] DROP_NONPRINT = 2'd3;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'd11;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [REASON_W-1:0]   reason_t;
  typedef logic [PADDR_W-1:0]    paddr_t;
  typedef logic [PDATA_W-1:0]    pdata_t;

endpackage

`default_nettype wire

[src/ala_ram.sv]
// ---------------------------------------------------------------------------
// ala_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held when idle.
// ---------------------------------------------------------------------------
`default_nettype none

module ala_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/ascii_line_assembler_core.sv]
// A drop result appears in the cycle after the byte that causes it; the first
// character of an accepted line passes through the replay state, the line store
// read register and the output register. One byte is taken per cycle while
// collecting and the output is not stalled; an accepted line holds off input
// until its last character loads. Reset is synchronous: it clears the line,
// counters and registers (enable 0, out_size 65), but not the line store.
// ---------------------------------------------------------------------------
// ascii_line_assembler_core: CR/LF line assembler with trim and drop checks
// Collects bytes into a line store, trims whitespace, checks length and
// printability, and replays accepted lines one character per request.
// ---------------------------------------------------------------------------
`default_nettype none

module ascii_line_assembler_core (
  input  wire logic            clk,
  input  wire logic            rst,
  // Configuration port
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire ala_pkg::paddr_t paddr,
  input  wire ala_pkg::pdata_t pwdata,
  output ala_pkg::pdata_t      prdata,
  output logic                 pready,
  // Input channel
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ala_pkg::byte_t  rx_byte,
  // Output channel
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 kind,
  output ala_pkg::byte_t       data_byte,
  output logic                 last,
  output ala_pkg::reason_t     drop_reason,
  output ala_pkg::count_t      line_count,
  output ala_pkg::count_t      drop_count
);

  import ala_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  // Registers
  logic                  enable;
  logic [OUT_SIZE_W-1:0] out_size;
  logic                  state;
  logic [LEN_W-1:0]      line_len;
  logic [LEN_W-1:0]      first_idx;
  logic [LEN_W-1:0]      last_idx;
  logic                  bad_flag;
  logic                  pend_flag;
  logic [ADDR_W-1:0]     rd_addr;
  logic [LEN_W-1:0]      rd_left;
  logic [LEN_W-1:0]      emit_left;
  logic                  rd_pending;
  count_t                accepted_lines;
  count_t                dropped_lines;

  // Combinational helpers
  logic             cfg_write;
  logic             out_free;
  logic             in_take;
  logic             active;
  logic             is_end;
  logic             is_blank;
  logic             is_nonprint;
  logic             full;
  logic [LEN_W-1:0] trim_len;
  logic             too_long;
  logic             rd_issue;
  logic             rd_load;
  logic             ram_we;
  byte_t            ram_rdata;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      out_size <= OUT_SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ENABLE:   enable   <= pwdata[0];
        REG_OUT_SIZE: out_size <= pwdata[OUT_SIZE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE:   prdata = {{(PDATA_W-1){1'b0}}, enable};
      REG_OUT_SIZE: prdata = {{(PDATA_W-OUT_SIZE_W){1'b0}}, out_size};
      default:      prdata = '0;
    endcase
  end

  // Handshake: take a byte only while collecting and the output can load
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_COLLECT) || !out_free;
  assign in_take  = in_valid && !in_stall;
  assign active   = in_take && enable && (out_size >= OUT_SIZE_MIN);

  // Byte classification
  assign is_end      = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign is_blank    = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                       (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_nonprint = (rx_byte < CH_SPACE) || (rx_byte > CH_TILDE);
  assign full        = (line_len == LEN_W'(LINE_MAX));
  assign trim_len    = last_idx - first_idx;
  assign too_long    = OUT_SIZE_W'(trim_len) >= out_size;

  // Store a byte while collecting
  assign ram_we = active && !is_end && !full;

  // Replay reads: issue when the read register is free or being drained
  assign rd_load  = (state == ST_EMIT) && rd_pending && out_free;
  assign rd_issue = (state == ST_EMIT) && (rd_left != '0) && (!rd_pending || out_free);

  ala_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_len[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Line tracking, counters and replay control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_COLLECT;
      line_len       <= '0;
      first_idx      <= '0;
      last_idx       <= '0;
      bad_flag       <= 1'b0;
      pend_flag      <= 1'b0;
      rd_left        <= '0;
      emit_left      <= '0;
      rd_pending     <= 1'b0;
      accepted_lines <= '0;
      dropped_lines  <= '0;
    end else begin
      if (active) begin
        if (!is_end) begin
          if (full) begin
            // Overflow: drop the line and discard the byte
            dropped_lines <= dropped_lines + 1'b1;
            line_len      <= '0;
            first_idx     <= '0;
            last_idx      <= '0;
            bad_flag      <= 1'b0;
            pend_flag     <= 1'b0;
          end else begin
            line_len <= line_len + 1'b1;
            if (!is_blank) begin
              if (last_idx == '0) begin
                first_idx <= line_len;
              end
              last_idx  <= line_len + 1'b1;
              // A held blank control byte is now interior
              if (pend_flag || is_nonprint) begin
                bad_flag <= 1'b1;
              end
              pend_flag <= 1'b0;
            end else if (is_nonprint && (last_idx != '0)) begin
              pend_flag <= 1'b1;
            end
          end
        end else begin
          // Line end: judge the trimmed line, then clear
          if (last_idx != '0) begin
            if (too_long || bad_flag) begin
              dropped_lines <= dropped_lines + 1'b1;
            end else begin
              accepted_lines <= accepted_lines + 1'b1;
              state          <= ST_EMIT;
              rd_left        <= trim_len;
              emit_left      <= trim_len;
            end
          end
          line_len  <= '0;
          first_idx <= '0;
          last_idx  <= '0;
          bad_flag  <= 1'b0;
          pend_flag <= 1'b0;
        end
      end

      if (rd_issue) begin
        rd_left <= rd_left - 1'b1;
      end
      if (rd_issue) begin
        rd_pending <= 1'b1;
      end else if (rd_load) begin
        rd_pending <= 1'b0;
      end
      if (rd_load) begin
        emit_left <= emit_left - 1'b1;
        if (emit_left == LEN_W'(1)) begin
          state <= ST_COLLECT;
        end
      end
    end
  end

  // Replay read address: start at the first kept character, then advance
  always_ff @(posedge clk) begin
    if (active && is_end) begin
      rd_addr <= first_idx[ADDR_W-1:0];
    end else if (rd_issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rd_load ||
                   (active && !is_end && full) ||
                   (active && is_end && (last_idx != '0) && (too_long || bad_flag));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_load) begin
      kind        <= KIND_CHAR;
      data_byte   <= ram_rdata;
      last        <= (emit_left == LEN_W'(1));
      drop_reason <= DROP_NONE;
    end else if (active) begin
      kind      <= KIND_DROP;
      data_byte <= '0;
      last      <= 1'b1;
      if (!is_end) begin
        drop_reason <= DROP_OVERFLOW;
      end else if (too_long) begin
        drop_reason <= DROP_TOO_LONG;
      end else begin
        drop_reason <= DROP_NONPRINT;
      end
    end
  end

  // Counters drive the outputs directly; the accepted count steps at the line end
  assign line_count = accepted_lines;
  assign drop_count = dropped_lines;

  // Checks
  a_pending_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == ST_EMIT))
    else $error("read pending outside replay");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) == (emit_left != '0))
    else $error("replay count out of step with state");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DROP)) |-> (last && (drop_reason != DROP_NONE)))
    else $error("drop request without last or reason");

  a_line_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (line_count != $past(line_count))) |->
      (line_count == $past(line_count) + 1'b1))
    else $error("line counter jumped");

endmodule

`default_nettype wire
